// ===== hw/rtl/vn_pkg.sv =====
package vn_pkg;

  typedef struct packed {
    logic en;
    logic vld;
  } vn_ctl_t;

endpackage

// ===== hw/rtl/vn_sqrt.sv =====
module vn_sqrt #(
  parameter int W  = 32,
  parameter int SB = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vn_pkg::vn_ctl_t   ctl_i,
  input  logic [2*W-1:0]    rad_i,
  input  logic [SB-1:0]     sb_i,
  output logic              vld_o,
  output logic [W-1:0]      root_o,
  output logic [SB-1:0]     sb_o
);
  import vn_pkg::*;

  logic [2*W-1:0] rad_q  [W];
  logic [W+1:0]   rem_q  [W];
  logic [W-1:0]   root_q [W];
  logic [SB-1:0]  sb_q   [W];
  logic           vld_q  [W];

  for (genvar i = 0; i < W; i++) begin : g_stage
    logic [2*W-1:0] p_rad;
    logic [W+1:0]   p_rem;
    logic [W-1:0]   p_root;
    logic [SB-1:0]  p_sb;
    logic           p_vld;
    logic [W+1:0]   r2;
    logic [W+1:0]   trial;
    logic           take;

    if (i == 0) begin : g_first
      assign p_rad  = rad_i;
      assign p_rem  = '0;
      assign p_root = '0;
      assign p_sb   = sb_i;
      assign p_vld  = ctl_i.vld;
    end else begin : g_next
      assign p_rad  = rad_q[i-1];
      assign p_rem  = rem_q[i-1];
      assign p_root = root_q[i-1];
      assign p_sb   = sb_q[i-1];
      assign p_vld  = vld_q[i-1];
    end

    assign r2    = {p_rem[W-1:0], p_rad[2*W-1:2*W-2]};
    assign trial = {p_root, 2'b01};
    assign take  = (r2 >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (ctl_i.en) begin
        vld_q[i] <= p_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        rad_q[i]  <= {p_rad[2*W-3:0], 2'b00};
        rem_q[i]  <= take ? (r2 - trial) : r2;
        root_q[i] <= {p_root[W-2:0], take};
        sb_q[i]   <= p_sb;
      end
    end
  end

  assign vld_o  = vld_q[W-1];
  assign root_o = root_q[W-1];
  assign sb_o   = sb_q[W-1];

endmodule

// ===== hw/rtl/vn_div.sv =====
module vn_div #(
  parameter int W  = 32,
  parameter int F  = 30,
  parameter int SB = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  vn_pkg::vn_ctl_t  ctl_i,
  input  logic [W-1:0]     num_i,
  input  logic [W-1:0]     den_i,
  input  logic [SB-1:0]    sb_i,
  output logic             vld_o,
  output logic [F:0]       quo_o,
  output logic [SB-1:0]    sb_o
);
  import vn_pkg::*;

  localparam int N = F + 1;

  logic [W-1:0]  rem_q [N];
  logic [W-1:0]  den_q [N];
  logic [F:0]    quo_q [N];
  logic [SB-1:0] sb_q  [N];
  logic          vld_q [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [W:0]    p_r;
    logic [W-1:0]  p_den;
    logic [F:0]    p_quo;
    logic [SB-1:0] p_sb;
    logic          p_vld;
    logic          take;
    logic [W:0]    diff;

    // numerator never exceeds divisor, so the top quotient bit is a plain compare
    if (i == 0) begin : g_first
      assign p_r   = {1'b0, num_i};
      assign p_den = den_i;
      assign p_quo = '0;
      assign p_sb  = sb_i;
      assign p_vld = ctl_i.vld;
    end else begin : g_next
      assign p_r   = {rem_q[i-1], 1'b0};
      assign p_den = den_q[i-1];
      assign p_quo = quo_q[i-1];
      assign p_sb  = sb_q[i-1];
      assign p_vld = vld_q[i-1];
    end

    assign take = (p_r >= {1'b0, p_den});
    assign diff = p_r - {1'b0, p_den};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (ctl_i.en) begin
        vld_q[i] <= p_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        rem_q[i] <= take ? diff[W-1:0] : p_r[W-1:0];
        den_q[i] <= p_den;
        quo_q[i] <= {p_quo[F-1:0], take};
        sb_q[i]  <= p_sb;
      end
    end
  end

  assign vld_o = vld_q[N-1];
  assign quo_o = quo_q[N-1];
  assign sb_o  = sb_q[N-1];

endmodule

// ===== hw/rtl/vector3_normalizer_core.sv =====
// 3D vector normalizer.
// Slave stream: one transfer carries a vector (in_x, in_y, in_z), signed Q16.16,
// IN_WIDTH bits each. Master stream: one transfer per vector with unit_x/y/z in
// signed Q2.30 (1.0 = 2^OUT_FRAC), length = floor(sqrt(x^2+y^2+z^2)) in Q16.16,
// and ok in tuser (0 for the zero vector, with all other fields zero).
// Pipeline: absolute value, squaring, sum, one square root stage per result
// bit, one divider stage per quotient bit, then sign and output register.
// Throughput: one vector per cycle when not stalled. Every stage holds a
// valid bit and the whole pipeline advances together whenever the output
// register is empty or being taken; s_axis_tready is that advance enable.
// Stall: when m_axis_tready is low with a result waiting, the pipeline freezes
// and tdata/tuser hold; nothing is dropped or repeated.
// Reset: clears all valid bits; the block accepts a transfer once rst_ni rises.
module vector3_normalizer_core #(
  parameter int IN_WIDTH = 32,
  parameter int OUT_FRAC = 30
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // in_x, in_y, in_z, zero fill
  input  logic [((3*IN_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // unit_x, unit_y, unit_z, length
  output logic [127:0]                          m_axis_tdata,
  // ok
  output logic                                  m_axis_tuser
);
  import vn_pkg::*;

  localparam int W  = IN_WIDTH;
  localparam int F  = OUT_FRAC;
  localparam int SS = 3 * W + 3;

  logic    en;
  vn_ctl_t ctl_sum, ctl_dv;

  logic           s1_vld_q, s2_vld_q, s3_vld_q;
  logic [W-1:0]   s1_mag_q [3];
  logic [2:0]     s1_neg_q, s2_neg_q, s3_neg_q;
  logic [2*W-1:0] s2_sq_q  [3];
  logic [W-1:0]   s2_mag_q [3];
  logic [2*W-1:0] s3_sum_q;
  logic [W-1:0]   s3_mag_q [3];

  logic           sq_vld;
  logic [W-1:0]   sq_root;
  logic [SS-1:0]  sq_sb;
  logic [W-1:0]   dv_mag [3];
  logic [2:0]     dv_neg;

  logic           dx_vld, dy_vld, dz_vld;
  logic [F:0]     quo [3];
  logic [W:0]     dx_sb;
  logic [0:0]     dy_sb, dz_sb;

  logic           m_vld_q;
  logic [31:0]    ux_q, uy_q, uz_q, len_q;
  logic           ok_q;
  logic [31:0]    unit_d [3];
  logic [W-1:0]   len_d;
  logic           ok_d;

  assign en            = !m_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  for (genvar c = 0; c < 3; c++) begin : g_comp
    logic [W-1:0] raw;
    assign raw = s_axis_tdata[c*W +: W];
    always_ff @(posedge clk_i) begin
      if (en) begin
        s1_mag_q[c] <= raw[W-1] ? (~raw + 1'b1) : raw;
        s2_sq_q[c]  <= (2*W)'(s1_mag_q[c]) * (2*W)'(s1_mag_q[c]);
        s2_mag_q[c] <= s1_mag_q[c];
        s3_mag_q[c] <= s2_mag_q[c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_neg_q <= {s_axis_tdata[3*W-1], s_axis_tdata[2*W-1], s_axis_tdata[W-1]};
      s2_neg_q <= s1_neg_q;
      s3_neg_q <= s2_neg_q;
      s3_sum_q <= s2_sq_q[0] + s2_sq_q[1] + s2_sq_q[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= s_axis_tvalid;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  assign ctl_sum = '{en: en, vld: s3_vld_q};

  vn_sqrt #(.W(W), .SB(SS)) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl_sum),
    .rad_i  (s3_sum_q),
    .sb_i   ({s3_neg_q, s3_mag_q[2], s3_mag_q[1], s3_mag_q[0]}),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .sb_o   (sq_sb)
  );

  assign dv_mag[0] = sq_sb[W-1:0];
  assign dv_mag[1] = sq_sb[2*W-1:W];
  assign dv_mag[2] = sq_sb[3*W-1:2*W];
  assign dv_neg    = sq_sb[3*W+2:3*W];
  assign ctl_dv    = '{en: en, vld: sq_vld};

  vn_div #(.W(W), .F(F), .SB(W+1)) u_div_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl_dv),
    .num_i  (dv_mag[0]),
    .den_i  (sq_root),
    .sb_i   ({sq_root, dv_neg[0]}),
    .vld_o  (dx_vld),
    .quo_o  (quo[0]),
    .sb_o   (dx_sb)
  );

  vn_div #(.W(W), .F(F), .SB(1)) u_div_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl_dv),
    .num_i  (dv_mag[1]),
    .den_i  (sq_root),
    .sb_i   (dv_neg[1]),
    .vld_o  (dy_vld),
    .quo_o  (quo[1]),
    .sb_o   (dy_sb)
  );

  vn_div #(.W(W), .F(F), .SB(1)) u_div_z (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl_dv),
    .num_i  (dv_mag[2]),
    .den_i  (sq_root),
    .sb_i   (dv_neg[2]),
    .vld_o  (dz_vld),
    .quo_o  (quo[2]),
    .sb_o   (dz_sb)
  );

  always_comb begin
    logic [2:0]  ng;
    logic [31:0] qe;
    ng    = {dz_sb[0], dy_sb[0], dx_sb[0]};
    len_d = dx_sb[W:1];
    ok_d  = (len_d != '0);
    for (int c = 0; c < 3; c++) begin
      qe = 32'(quo[c]);
      if (!ok_d) begin
        unit_d[c] = '0;
      end else begin
        unit_d[c] = ng[c] ? (~qe + 32'd1) : qe;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (en) begin
      m_vld_q <= dx_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ux_q  <= unit_d[0];
      uy_q  <= unit_d[1];
      uz_q  <= unit_d[2];
      len_q <= 32'(len_d);
      ok_q  <= ok_d;
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = {len_q, uz_q, uy_q, ux_q};
  assign m_axis_tuser  = ok_q;

  a_ready_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("ready does not follow output register state");

  a_ok_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == (len_q != 32'd0)))
    else $error("ok flag disagrees with length");

  a_zero_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (ux_q == '0 && uy_q == '0 && uz_q == '0))
    else $error("zero vector gave nonzero unit components");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ($signed(ux_q) <= $signed(32'd1 << F)) && ($signed(ux_q) >= -$signed(32'd1 << F)))
    else $error("unit x out of range");

  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dx_vld == dy_vld) && (dx_vld == dz_vld))
    else $error("divider lanes out of step");

endmodule

// ===== tb/vector3_normalizer_checker.sv =====
module vector3_normalizer_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_valid_i,
  input  logic         s_ready_i,
  input  logic [95:0]  s_data_i,
  input  logic         m_valid_i,
  input  logic         m_ready_i,
  input  logic [127:0] m_data_i,
  input  logic         m_user_i,
  output int           errors_o,
  output int           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        ok;
    logic [31:0] len;
    logic [31:0] uz;
    logic [31:0] uy;
    logic [31:0] ux;
  } unit_vec_t;

  unit_vec_t want_q[$];
  int        err_q = 0;

  function automatic logic [31:0] floor_sqrt(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r[31:0];
  endfunction

  function automatic unit_vec_t normalize(logic [95:0] d);
    unit_vec_t   u;
    logic [63:0] mag [3];
    logic        neg [3];
    logic [63:0] sum;
    logic [63:0] q;
    logic [31:0] c;
    logic [31:0] res [3];
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      c = d[32*i +: 32];
      neg[i] = c[31];
      mag[i] = {32'd0, (neg[i] ? (~c + 32'd1) : c)};
      sum = sum + mag[i] * mag[i];
    end
    u.len = floor_sqrt(sum);
    u.ok = (u.len != 0);
    for (int i = 0; i < 3; i++) begin
      q = u.ok ? (mag[i] << 30) / {32'd0, u.len} : 64'd0;
      if (neg[i]) q = 64'd0 - q;
      res[i] = q[31:0];
    end
    if (!u.ok) u.len = '0;
    u.ux = res[0];
    u.uy = res[1];
    u.uz = res[2];
    return u;
  endfunction

  assign pending_o = want_q.size();
  assign errors_o  = err_q;

  always @(posedge clk_i) begin
    unit_vec_t w;
    unit_vec_t g;
    if (rst_ni) begin
      if (s_valid_i && s_ready_i) want_q.push_back(normalize(s_data_i));
      if (m_valid_i && m_ready_i) begin
        g = {m_user_i, m_data_i};
        if (want_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, g);
          err_q <= err_q + 1;
        end else begin
          w = want_q.pop_front();
          if (w !== g) begin
            $display("%0t: mismatch exp ok=%b len=%h u=%h %h %h got ok=%b len=%h u=%h %h %h",
                     $time, w.ok, w.len, w.ux, w.uy, w.uz, g.ok, g.len, g.ux, g.uy, g.uz);
            err_q <= err_q + 1;
          end
        end
      end
    end
  end
endmodule

// ===== tb/vector3_normalizer_core_test.sv =====
module vector3_normalizer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 67;
  localparam int WATCHDOG = 5000;
  localparam int HOLD_CYCLES = 300;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_valid = 1'b0;
  logic         s_ready;
  logic [95:0]  s_data = '0;
  logic         m_valid;
  logic         m_ready = 1'b0;
  logic [127:0] m_data;
  logic         m_user;
  int           errors;
  int           pending;
  bit           no_idle = 1'b0;
  bit           hold_go = 1'b0;
  bit           hold_rx = 1'b0;
  int           idle_cnt = 0;

  always #5 clk_i = ~clk_i;

  vector3_normalizer_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user)
  );

  vector3_normalizer_checker chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_valid),
    .s_ready_i (s_ready),
    .s_data_i  (s_data),
    .m_valid_i (m_valid),
    .m_ready_i (m_ready),
    .m_data_i  (m_data),
    .m_user_i  (m_user),
    .errors_o  (errors),
    .pending_o (pending)
  );

  // long receiver hold-off, timed here while the sender keeps offering
  initial begin
    @(posedge hold_go);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  // receiver: random stall bursts, or a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_rx) begin
      m_ready <= 1'b0;
    end else if (idle_cnt > 0) begin
      idle_cnt <= idle_cnt - 1;
      m_ready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 7) == 0) begin
      idle_cnt <= $urandom_range(0, 16);
      m_ready <= 1'b0;
    end else begin
      m_ready <= 1'b1;
    end
  end

  int stuck = 0;
  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) stuck <= 0;
    else stuck <= stuck + 1;
    if (stuck > WATCHDOG) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000 + $urandom_range(0, 3);
      1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      2: return $urandom_range(0, 3) - 1;
      3: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic send(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit gaps);
    int gap;
    if (gaps && !no_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data <= {z, y, x};
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] ext [6];
    ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1, 32'hFFFF_FFFF, 32'h0001_0000};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send(0, 0, 0, 0);
    send(1, 1, 0, 0);
    send(32'hFFFF_FFFF, 0, 1, 0);
    send(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
    send(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    send(32'h0001_0000, 0, 0, 0);
    send(0, 32'hFFFF_0000, 0, 0);
    for (int i = 0; i < 6; i++) send(ext[i], ext[5 - i], ext[(i + 2) % 6], 0);
    for (int i = 0; i < 4; i++) send(32'h5555_5555 << i, 32'hAAAA_AAAA >> i, ~i, 0);
    drain();
    hold_go <= 1'b1;
    for (int i = 0; i < 120; i++) send(rand_comp(), rand_comp(), rand_comp(), 0);
    drain();
    for (int i = 0; i < 200; i++) send(rand_comp(), rand_comp(), rand_comp(), 1);
    no_idle <= 1'b1;
    for (int i = 0; i < 80; i++) send(rand_comp(), rand_comp(), rand_comp(), 1);
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
